// File: rtl/bpdr_pkg.sv
package bpdr_pkg;

  localparam int SAMPLE_W = 10;
  localparam int MV_W     = 16;
  localparam int TGT_W    = 14;
  localparam int DUTY_W   = 8;
  localparam int MUL_A_W  = 17;
  localparam int MUL_B_W  = 19;
  localparam int PROD_W   = 36;
  localparam int M_W      = 46;
  localparam int REM_W    = 31;
  localparam int QUO_W    = 9;
  localparam int CFG_IDX_W = 3;

  localparam logic [MV_W-1:0]   OVERVOLT_MV    = 16'd14000;
  localparam logic [MV_W-1:0]   VIN_MV         = 16'd1500;
  localparam logic [MV_W-1:0]   NEAR_MV        = 16'd400;
  localparam logic [TGT_W-1:0]  TARGET_STEP_MV = 14'd100;
  localparam logic [TGT_W-1:0]  TARGET_MIN_MV  = 14'd2000;
  localparam logic [TGT_W-1:0]  TARGET_MAX_MV  = 14'd10000;
  localparam logic [TGT_W-1:0]  TARGET_RESET   = 14'd5000;
  localparam logic [DUTY_W-1:0] DUTY_RESET     = 8'd120;
  localparam logic [DUTY_W-1:0] DUTY_MAX       = 8'd255;

  // 4096000 = 125 << 15; floor(h / 125) = (h * RECIP_M) >> 24 for h below 64000
  localparam logic [REM_W-1:0]  DIV_C          = 31'd4096000;
  localparam logic [M_W-1:0]    SAT_LIM        = 46'd2097152000;
  localparam logic [17:0]       RECIP_M        = 18'd134218;
  localparam logic [6:0]        DIV_ODD        = 7'd125;

  localparam logic [15:0] ADC_SCALE_RESET  = 16'd18767;
  localparam logic [15:0] GAIN_RESET       = 16'd410;
  localparam logic [15:0] INTEG_MAX_RESET  = 16'd1000;
  localparam logic [15:0] INTEG_MIN_RESET  = 16'd10;
  localparam logic [7:0]  DUTY_PER_V_RESET = 8'd50;
  localparam logic [7:0]  DUTY_LIMIT_RESET = 8'd240;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADC_SCALE,
    REG_PROP_GAIN,
    REG_INTEG_GAIN,
    REG_DERIV_GAIN,
    REG_INTEG_MAX,
    REG_INTEG_MIN,
    REG_DUTY_PER_VOLT,
    REG_DUTY_LIMIT
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_V,
    ST_CHECK,
    ST_TEST,
    ST_INTEG,
    ST_MUL_I,
    ST_MUL_D,
    ST_SUM,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ADD_HI,
    ST_ABS,
    ST_DIV,
    ST_QUO,
    ST_FINISH
  } state_t;

endpackage

// File: rtl/bpdr_mul.sv
module bpdr_mul (
  input  logic                                clk,
  input  logic signed [bpdr_pkg::MUL_A_W-1:0] a,
  input  logic signed [bpdr_pkg::MUL_B_W-1:0] b,
  output logic signed [bpdr_pkg::PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// File: rtl/boost_pid_duty_regulator.sv
// Path: an item inside tolerance goes from MUL_V through CHECK and TEST to FINISH and the
// output register; an item that runs the PID step also passes the multiply states, then one
// reciprocal multiply for the quotient, through one shared registered 17x19 multiplier.
// Flow: no new item is taken until the last one leaves FINISH; the next item is taken while
// a result waits, and a stalled output holds the following item in its last step.
// Reset: synchronous; config, state and control registers reset: duty accumulator 120,
// target 5000 mV, integrator, previous vout and held duty 0, output register empty.
module boost_pid_duty_regulator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [bpdr_pkg::SAMPLE_W-1:0]         adc_sample,
  input  logic                                  button_up,
  input  logic                                  button_down,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [bpdr_pkg::DUTY_W-1:0]           duty,
  output logic                                  near_target,
  output logic [bpdr_pkg::MV_W-1:0]             vout_mv,
  output logic [bpdr_pkg::TGT_W-1:0]            target_mv,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bpdr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [15:0]                           cfg_data
);

  bpdr_pkg::state_t state, state_next;

  logic [15:0] adc_scale, prop_gain, integ_gain, deriv_gain, integ_max_mv, integ_min_mv;
  logic [7:0]  duty_per_volt, duty_limit;

  logic [bpdr_pkg::SAMPLE_W-1:0] sample;
  logic                          up_q, down_q;
  logic [bpdr_pkg::MV_W-1:0]     vout, integ_state, prev_vout;
  logic signed [16:0]            err, delta;
  logic                          run, ovr, near;
  logic [bpdr_pkg::DUTY_W-1:0]   duty_acc, duty_out;
  logic [bpdr_pkg::TGT_W-1:0]    target;
  logic signed [bpdr_pkg::PROD_W-1:0] k_acc;
  logic signed [bpdr_pkg::M_W-1:0]    m_acc;
  logic                          neg, sat;
  logic [bpdr_pkg::REM_W-1:0]    rem;
  logic                          rem_nz;
  logic [bpdr_pkg::QUO_W-1:0]    quo;

  logic signed [bpdr_pkg::MUL_A_W-1:0] mul_a;
  logic signed [bpdr_pkg::MUL_B_W-1:0] mul_b;
  logic signed [bpdr_pkg::PROD_W-1:0]  prod;

  logic                          load;
  logic [bpdr_pkg::MV_W-1:0]     vout_c, aerr_c, integ_c;
  logic signed [16:0]            err_c, delta_c;
  logic [20:0]                   tol_c;
  logic signed [21:0]            lhs_c, rhs_c;
  logic                          run_c, ovr_c, near_c;
  logic signed [17:0]            isum_c;
  logic [bpdr_pkg::M_W-1:0]      mag_c;
  logic [15:0]                   qmul_c;
  logic [9:0]                    cq_c, sq_c;
  logic [bpdr_pkg::DUTY_W-1:0]   dnew_c, dout_c;
  logic [bpdr_pkg::TGT_W-1:0]    tup_c, tnew_c;

  assign cfg_ready = 1'b1;

  bpdr_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      adc_scale     <= bpdr_pkg::ADC_SCALE_RESET;
      prop_gain     <= bpdr_pkg::GAIN_RESET;
      integ_gain    <= bpdr_pkg::GAIN_RESET;
      deriv_gain    <= bpdr_pkg::GAIN_RESET;
      integ_max_mv  <= bpdr_pkg::INTEG_MAX_RESET;
      integ_min_mv  <= bpdr_pkg::INTEG_MIN_RESET;
      duty_per_volt <= bpdr_pkg::DUTY_PER_V_RESET;
      duty_limit    <= bpdr_pkg::DUTY_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (bpdr_pkg::cfg_idx_t'(cfg_index))
        bpdr_pkg::REG_ADC_SCALE:     adc_scale     <= cfg_data;
        bpdr_pkg::REG_PROP_GAIN:     prop_gain     <= cfg_data;
        bpdr_pkg::REG_INTEG_GAIN:    integ_gain    <= cfg_data;
        bpdr_pkg::REG_DERIV_GAIN:    deriv_gain    <= cfg_data;
        bpdr_pkg::REG_INTEG_MAX:     integ_max_mv  <= cfg_data;
        bpdr_pkg::REG_INTEG_MIN:     integ_min_mv  <= cfg_data;
        bpdr_pkg::REG_DUTY_PER_VOLT: duty_per_volt <= cfg_data[7:0];
        bpdr_pkg::REG_DUTY_LIMIT:    duty_limit    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      bpdr_pkg::ST_MUL_V: begin
        mul_a = $signed({1'b0, adc_scale});
        mul_b = $signed({9'b0, sample});
      end
      bpdr_pkg::ST_INTEG: begin
        mul_a = $signed({1'b0, prop_gain});
        mul_b = {{2{err[16]}}, err};
      end
      bpdr_pkg::ST_MUL_I: begin
        mul_a = $signed({1'b0, integ_gain});
        mul_b = $signed({3'b0, integ_state});
      end
      bpdr_pkg::ST_MUL_D: begin
        mul_a = $signed({1'b0, deriv_gain});
        mul_b = {{2{delta[16]}}, delta};
      end
      bpdr_pkg::ST_MUL_LO: begin
        mul_a = $signed({9'b0, duty_per_volt});
        mul_b = $signed({1'b0, k_acc[17:0]});
      end
      bpdr_pkg::ST_MUL_HI: begin
        mul_a = $signed({9'b0, duty_per_volt});
        mul_b = $signed({k_acc[35], k_acc[35:18]});
      end
      bpdr_pkg::ST_DIV: begin
        mul_a = $signed({1'b0, rem[30:15]});
        mul_b = $signed({1'b0, bpdr_pkg::RECIP_M});
      end
      default: ;
    endcase
  end

  always_comb begin
    vout_c  = prod[25:10];
    err_c   = $signed({1'b0, vout_c}) - $signed({3'b0, target});
    aerr_c  = err[16] ? 16'(-err) : err[15:0];
    tol_c   = 21'({aerr_c, 4'b0}) + 21'({aerr_c, 2'b0});
    lhs_c   = $signed({1'b0, tol_c});
    rhs_c   = $signed({6'b0, vout}) - $signed({6'b0, bpdr_pkg::VIN_MV});
    run_c   = !(lhs_c < rhs_c);
    ovr_c   = vout > bpdr_pkg::OVERVOLT_MV;
    near_c  = aerr_c <= bpdr_pkg::NEAR_MV;
    isum_c  = $signed({2'b0, integ_state}) + $signed({err[16], err});
    delta_c = $signed({1'b0, prev_vout}) - $signed({1'b0, vout});
    if (isum_c > $signed({2'b0, integ_max_mv})) begin
      integ_c = integ_max_mv;
    end else if (isum_c < $signed({2'b0, integ_min_mv})) begin
      integ_c = integ_min_mv;
    end else begin
      integ_c = isum_c[15:0];
    end
    mag_c   = m_acc[bpdr_pkg::M_W-1] ? bpdr_pkg::M_W'(-m_acc) : m_acc;
    qmul_c  = {7'b0, prod[32:24]} * {9'b0, bpdr_pkg::DIV_ODD};

    cq_c = {1'b0, quo} + {9'b0, rem_nz};
    sq_c = {2'b0, duty_acc} + {1'b0, quo};
    if (!neg) begin
      dnew_c = (sat || (cq_c > {2'b0, duty_acc})) ? '0 : 8'(duty_acc - cq_c[7:0]);
    end else begin
      dnew_c = (sat || (sq_c > {2'b0, bpdr_pkg::DUTY_MAX})) ? bpdr_pkg::DUTY_MAX : sq_c[7:0];
    end
    if (!run) begin
      dnew_c = duty_acc;
      dout_c = duty_out;
    end else begin
      dout_c = (dnew_c > duty_limit) ? duty_limit : dnew_c;
    end
    if (ovr) begin
      dout_c = '0;
    end

    tup_c  = (up_q && (target < bpdr_pkg::TARGET_MAX_MV)) ?
             target + bpdr_pkg::TARGET_STEP_MV : target;
    tnew_c = (down_q && (tup_c > bpdr_pkg::TARGET_MIN_MV)) ?
             tup_c - bpdr_pkg::TARGET_STEP_MV : tup_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpdr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = (state != bpdr_pkg::ST_IDLE);
    load       = 1'b0;
    case (state)
      bpdr_pkg::ST_IDLE:   if (in_valid) state_next = bpdr_pkg::ST_MUL_V;
      bpdr_pkg::ST_MUL_V:  state_next = bpdr_pkg::ST_CHECK;
      bpdr_pkg::ST_CHECK:  state_next = bpdr_pkg::ST_TEST;
      bpdr_pkg::ST_TEST:   state_next = run_c ? bpdr_pkg::ST_INTEG : bpdr_pkg::ST_FINISH;
      bpdr_pkg::ST_INTEG:  state_next = bpdr_pkg::ST_MUL_I;
      bpdr_pkg::ST_MUL_I:  state_next = bpdr_pkg::ST_MUL_D;
      bpdr_pkg::ST_MUL_D:  state_next = bpdr_pkg::ST_SUM;
      bpdr_pkg::ST_SUM:    state_next = bpdr_pkg::ST_MUL_LO;
      bpdr_pkg::ST_MUL_LO: state_next = bpdr_pkg::ST_MUL_HI;
      bpdr_pkg::ST_MUL_HI: state_next = bpdr_pkg::ST_ADD_HI;
      bpdr_pkg::ST_ADD_HI: state_next = bpdr_pkg::ST_ABS;
      bpdr_pkg::ST_ABS:    state_next = bpdr_pkg::ST_DIV;
      bpdr_pkg::ST_DIV:    state_next = bpdr_pkg::ST_QUO;
      bpdr_pkg::ST_QUO:    state_next = bpdr_pkg::ST_FINISH;
      bpdr_pkg::ST_FINISH: begin
        load = !out_valid || !out_stall;
        if (load) state_next = bpdr_pkg::ST_IDLE;
      end
      default: state_next = bpdr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ_state <= '0;
      prev_vout   <= '0;
      duty_acc    <= bpdr_pkg::DUTY_RESET;
      duty_out    <= '0;
      target      <= bpdr_pkg::TARGET_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        bpdr_pkg::ST_IDLE: begin
          sample <= adc_sample;
          up_q   <= button_up;
          down_q <= button_down;
        end
        bpdr_pkg::ST_CHECK: begin
          vout <= vout_c;
          err  <= err_c;
        end
        bpdr_pkg::ST_TEST: begin
          run  <= run_c;
          ovr  <= ovr_c;
          near <= near_c;
          if (ovr_c) duty_acc <= '0;
        end
        bpdr_pkg::ST_INTEG: begin
          integ_state <= integ_c;
          delta       <= delta_c;
          prev_vout   <= vout;
        end
        bpdr_pkg::ST_MUL_I:  k_acc <= prod;
        bpdr_pkg::ST_MUL_D:  k_acc <= k_acc + prod;
        bpdr_pkg::ST_SUM:    k_acc <= k_acc + prod;
        bpdr_pkg::ST_MUL_HI: m_acc <= {{(bpdr_pkg::M_W-bpdr_pkg::PROD_W){prod[35]}}, prod};
        bpdr_pkg::ST_ADD_HI: m_acc <= m_acc + $signed({prod[27:0], 18'b0});
        bpdr_pkg::ST_ABS: begin
          neg <= m_acc[bpdr_pkg::M_W-1];
          sat <= mag_c >= bpdr_pkg::SAT_LIM;
          rem <= mag_c[bpdr_pkg::REM_W-1:0];
        end
        bpdr_pkg::ST_QUO: begin
          quo    <= prod[32:24];
          rem_nz <= (rem[14:0] != '0) || (rem[30:15] != qmul_c);
        end
        bpdr_pkg::ST_FINISH: begin
          if (load) begin
            duty_acc    <= dnew_c;
            duty_out    <= dout_c;
            target      <= tnew_c;
            duty        <= dout_c;
            near_target <= near;
            vout_mv     <= vout;
            target_mv   <= target;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/bpdr_checker.sv
module bpdr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [bpdr_pkg::DUTY_W-1:0] duty,
  input logic [bpdr_pkg::MV_W-1:0]   vout_mv,
  input logic [bpdr_pkg::TGT_W-1:0]  target_mv
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while item in work");

  a_overvolt_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && (vout_mv > bpdr_pkg::OVERVOLT_MV) |-> duty == '0)
    else $error("duty not zero above overvoltage");

  a_target_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (target_mv >= bpdr_pkg::TARGET_MIN_MV) &&
                  (target_mv <= bpdr_pkg::TARGET_MAX_MV))
    else $error("target out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(duty) && $stable(vout_mv))
    else $error("stalled item changed");

endmodule

bind boost_pid_duty_regulator bpdr_checker u_bpdr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .duty      (duty),
  .vout_mv   (vout_mv),
  .target_mv (target_mv)
);
